/* rtl/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types, codes and constants of the orbit histogram sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  localparam int FRAME_WIDTH_DEF  = 256;
  localparam int FRAME_HEIGHT_DEF = 256;
  localparam int CHANNELS_DEF     = 3;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 35;
  localparam int PROD_W = 70;
  localparam int Q_FRAC = 28;

  localparam int ONE_Q       = 1 << 28;
  localparam int QUARTER_Q   = 1 << 26;
  localparam int SIXTEENTH_Q = 1 << 24;
  localparam int ESC_RADIUS  = 1 << 30;

  localparam logic [31:0] X_MIN_RST  = 32'hE000_0000;
  localparam logic [31:0] Y_MIN_RST  = 32'hE800_0000;
  localparam logic [30:0] SPAN_RST   = 31'h3000_0000;
  localparam logic [31:0] PPU_RST    = 32'h0055_5555;
  localparam logic [15:0] LIMIT_RST  = 16'd1000;
  localparam logic [15:0] FLOOR_RST  = 16'd20;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_READ     = 2'd1,
    OP_READ_CLR = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_X_MIN  = 3'd0,
    REG_Y_MIN  = 3'd1,
    REG_X_SPAN = 3'd2,
    REG_Y_SPAN = 3'd3,
    REG_X_PPU  = 3'd4,
    REG_Y_PPU  = 3'd5,
    REG_LIMIT  = 3'd6,
    REG_FLOOR  = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_X,
    ST_DRAW_Y,
    ST_PLACE_MUL,
    ST_PLACE_ADD,
    ST_BULB_MUL,
    ST_BULB_SQ,
    ST_CARD_MUL,
    ST_BULB_EVAL,
    ST_ORB_CHK,
    ST_ORB_MUL,
    ST_ORB_UPD,
    ST_MAP_MUL,
    ST_MAP_CHK,
    ST_MAP_WR,
    ST_PASS_END,
    ST_RD_ISSUE,
    ST_RD_DONE,
    ST_FINISH
  } state_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_CLEAR,
    DP_LATCH,
    DP_DRAW_X,
    DP_DRAW_Y,
    DP_PLACE_MUL,
    DP_PLACE_ADD,
    DP_BULB_MUL,
    DP_BULB_SQ,
    DP_CARD_MUL,
    DP_PASS_INIT,
    DP_ORB_MUL,
    DP_ORB_UPD,
    DP_MAP_MUL,
    DP_MAP_CHK,
    DP_MAP_WR,
    DP_RD_ISSUE,
    DP_RD_DONE,
    DP_LOAD
  } dp_op_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ZERO,
    RES_BULB_REJ,
    RES_RANGE_REJ,
    RES_SAMPLE_OK,
    RES_READ
  } res_t;

  typedef struct packed {
    dp_op_t op;
    logic   map;
    logic   k_inc;
    res_t   res;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_bulb;
    logic k_lt_limit;
    logic escaped;
    logic reject_range;
    logic in_frame;
    logic ch_ok;
    logic map;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/bsa_if.sv */
// ----------------------------------------------------------------------------
// bsa_if
// Valid/ready channels of the sampler: request, result and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] channel;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  modport source (output valid, opcode, channel, pixel_x, pixel_y, input ready);
  modport sink   (input valid, opcode, channel, pixel_x, pixel_y, output ready);
endinterface

interface bsa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_count;
  logic        sample_accepted;
  logic [15:0] escape_iterations;
  logic [15:0] in_frame_hits;
  modport source (output valid, pixel_count, sample_accepted, escape_iterations,
                  in_frame_hits, input ready);
  modport sink   (input valid, pixel_count, sample_accepted, escape_iterations,
                  in_frame_hits, output ready);
endinterface

interface bsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/buddhabrot_sample_accumulator.sv */
// ----------------------------------------------------------------------------
// buddhabrot_sample_accumulator
// Random orbit sampler that builds per channel hit histograms of escaping
// orbits and reads or clears single pixel counts.
// ----------------------------------------------------------------------------
// After reset the histogram memory is swept to zero, one entry a cycle, over
// all CHANNELS*FRAME_WIDTH*FRAME_HEIGHT entries (196608 at the defaults); no
// item is taken during that sweep, register writes are. One item is worked
// at a time. A read passes through an issue and a done state before its
// result, a no-op goes straight to the result. A sample draws a point, tests
// it against the main cardioid and bulb, then runs an escape pass and, if it
// is kept, a mapping pass, iterating around the shared multipliers and the
// single histogram memory; the default iteration limit is 1000. A finished
// result waits in an output register, so the next item is taken while it is
// still unread.
// ----------------------------------------------------------------------------
`default_nettype none

module buddhabrot_sample_accumulator #(
  parameter int FRAME_WIDTH  = bsa_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = bsa_pkg::FRAME_HEIGHT_DEF,
  parameter int CHANNELS     = bsa_pkg::CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bsa_in_if.sink     in_ch,
  bsa_out_if.source  out_ch,
  bsa_cfg_if.sink    cfg_ch
);

  bsa_pkg::cmd_t cmd;
  bsa_pkg::sts_t sts;

  assign cfg_ch.ready = 1'b1;

  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (bsa_pkg::op_t'(in_ch.opcode)),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsa_dp #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .CHANNELS     (CHANNELS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_opcode             (in_ch.opcode),
    .in_channel            (in_ch.channel),
    .in_pixel_x            (in_ch.pixel_x),
    .in_pixel_y            (in_ch.pixel_y),
    .cfg_we                (cfg_ch.valid),
    .cfg_idx               (bsa_pkg::reg_idx_t'(cfg_ch.index)),
    .cfg_data              (cfg_ch.data),
    .out_ready             (out_ch.ready),
    .out_valid             (out_ch.valid),
    .out_pixel_count       (out_ch.pixel_count),
    .out_sample_accepted   (out_ch.sample_accepted),
    .out_escape_iterations (out_ch.escape_iterations),
    .out_in_frame_hits     (out_ch.in_frame_hits)
  );

endmodule

`default_nettype wire

/* rtl/bsa_ram.sv */
// ----------------------------------------------------------------------------
// bsa_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/bsa_ctrl.sv */
// ----------------------------------------------------------------------------
// bsa_ctrl
// Sequencer: clearing sweep, sampling, bulb test, two orbit passes, reads.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  bsa_pkg::op_t   in_op,
  output logic           in_ready,
  input  bsa_pkg::sts_t  sts,
  output bsa_pkg::cmd_t  cmd
);

  bsa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsa_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '{op: bsa_pkg::DP_NONE, map: 1'b0, k_inc: 1'b0, res: bsa_pkg::RES_NONE};
    unique case (state_r)
      bsa_pkg::ST_CLEAR: begin
        cmd.op = bsa_pkg::DP_CLEAR;
        if (sts.clr_last) state_nxt = bsa_pkg::ST_IDLE;
      end
      bsa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = bsa_pkg::DP_LATCH;
          unique case (in_op) inside
            bsa_pkg::OP_SAMPLE: state_nxt = bsa_pkg::ST_DRAW_X;
            bsa_pkg::OP_READ, bsa_pkg::OP_READ_CLR: state_nxt = bsa_pkg::ST_RD_ISSUE;
            default: begin
              cmd.res   = bsa_pkg::RES_ZERO;
              state_nxt = bsa_pkg::ST_FINISH;
            end
          endcase
        end
      end
      bsa_pkg::ST_DRAW_X: begin
        cmd.op    = bsa_pkg::DP_DRAW_X;
        state_nxt = bsa_pkg::ST_DRAW_Y;
      end
      bsa_pkg::ST_DRAW_Y: begin
        cmd.op    = bsa_pkg::DP_DRAW_Y;
        state_nxt = bsa_pkg::ST_PLACE_MUL;
      end
      bsa_pkg::ST_PLACE_MUL: begin
        cmd.op    = bsa_pkg::DP_PLACE_MUL;
        state_nxt = bsa_pkg::ST_PLACE_ADD;
      end
      bsa_pkg::ST_PLACE_ADD: begin
        cmd.op    = bsa_pkg::DP_PLACE_ADD;
        state_nxt = bsa_pkg::ST_BULB_MUL;
      end
      bsa_pkg::ST_BULB_MUL: begin
        cmd.op    = bsa_pkg::DP_BULB_MUL;
        state_nxt = bsa_pkg::ST_BULB_SQ;
      end
      bsa_pkg::ST_BULB_SQ: begin
        cmd.op    = bsa_pkg::DP_BULB_SQ;
        state_nxt = bsa_pkg::ST_CARD_MUL;
      end
      bsa_pkg::ST_CARD_MUL: begin
        cmd.op    = bsa_pkg::DP_CARD_MUL;
        state_nxt = bsa_pkg::ST_BULB_EVAL;
      end
      bsa_pkg::ST_BULB_EVAL: begin
        cmd.op = bsa_pkg::DP_PASS_INIT;
        if (sts.in_bulb) begin
          cmd.res   = bsa_pkg::RES_BULB_REJ;
          state_nxt = bsa_pkg::ST_FINISH;
        end else begin
          state_nxt = bsa_pkg::ST_ORB_CHK;
        end
      end
      bsa_pkg::ST_ORB_CHK: begin
        state_nxt = sts.k_lt_limit ? bsa_pkg::ST_ORB_MUL : bsa_pkg::ST_PASS_END;
      end
      bsa_pkg::ST_ORB_MUL: begin
        cmd.op    = bsa_pkg::DP_ORB_MUL;
        state_nxt = bsa_pkg::ST_ORB_UPD;
      end
      bsa_pkg::ST_ORB_UPD: begin
        cmd.op = bsa_pkg::DP_ORB_UPD;
        if (sts.escaped) begin
          state_nxt = bsa_pkg::ST_PASS_END;
        end else if (sts.map) begin
          state_nxt = bsa_pkg::ST_MAP_MUL;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = bsa_pkg::ST_ORB_CHK;
        end
      end
      bsa_pkg::ST_MAP_MUL: begin
        cmd.op    = bsa_pkg::DP_MAP_MUL;
        state_nxt = bsa_pkg::ST_MAP_CHK;
      end
      bsa_pkg::ST_MAP_CHK: begin
        cmd.op = bsa_pkg::DP_MAP_CHK;
        if (sts.in_frame && sts.ch_ok) begin
          state_nxt = bsa_pkg::ST_MAP_WR;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = bsa_pkg::ST_ORB_CHK;
        end
      end
      bsa_pkg::ST_MAP_WR: begin
        cmd.op    = bsa_pkg::DP_MAP_WR;
        cmd.k_inc = 1'b1;
        state_nxt = bsa_pkg::ST_ORB_CHK;
      end
      bsa_pkg::ST_PASS_END: begin
        if (sts.map) begin
          cmd.res   = bsa_pkg::RES_SAMPLE_OK;
          state_nxt = bsa_pkg::ST_FINISH;
        end else if (sts.reject_range) begin
          cmd.res   = bsa_pkg::RES_RANGE_REJ;
          state_nxt = bsa_pkg::ST_FINISH;
        end else begin
          cmd.op    = bsa_pkg::DP_PASS_INIT;
          cmd.map   = 1'b1;
          state_nxt = bsa_pkg::ST_ORB_CHK;
        end
      end
      bsa_pkg::ST_RD_ISSUE: begin
        cmd.op    = bsa_pkg::DP_RD_ISSUE;
        state_nxt = bsa_pkg::ST_RD_DONE;
      end
      bsa_pkg::ST_RD_DONE: begin
        cmd.op    = bsa_pkg::DP_RD_DONE;
        cmd.res   = bsa_pkg::RES_READ;
        state_nxt = bsa_pkg::ST_FINISH;
      end
      bsa_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          cmd.op    = bsa_pkg::DP_LOAD;
          state_nxt = bsa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bsa_pkg::ST_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/bsa_dp.sv */
// ----------------------------------------------------------------------------
// bsa_dp
// Datapath: registers, random source, three Q4.28 multipliers, orbit and
// pixel mapping arithmetic, histogram memory and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_dp #(
  parameter int FRAME_WIDTH  = bsa_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = bsa_pkg::FRAME_HEIGHT_DEF,
  parameter int CHANNELS     = bsa_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bsa_pkg::cmd_t      cmd,
  output bsa_pkg::sts_t      sts,
  input  logic [1:0]         in_opcode,
  input  logic [1:0]         in_channel,
  input  logic [7:0]         in_pixel_x,
  input  logic [7:0]         in_pixel_y,
  input  logic               cfg_we,
  input  bsa_pkg::reg_idx_t  cfg_idx,
  input  logic [31:0]        cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [31:0]        out_pixel_count,
  output logic               out_sample_accepted,
  output logic [15:0]        out_escape_iterations,
  output logic [15:0]        out_in_frame_hits
);

  localparam int BANK  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int DEPTH = CHANNELS * BANK;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int YW    = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int MLW   = bsa_pkg::MUL_W;
  localparam int PW    = bsa_pkg::PROD_W;
  localparam int QF    = bsa_pkg::Q_FRAC;
  localparam int MW    = PW - QF;
  localparam int PIX_SHIFT = QF + 16;
  localparam int TW    = PW - PIX_SHIFT;

  localparam logic signed [MLW-1:0] QUARTER_M = MLW'(bsa_pkg::QUARTER_Q);
  localparam logic signed [MLW-1:0] ONE_M     = MLW'(bsa_pkg::ONE_Q);
  localparam logic signed [31:0]    TWO_Q     = 32'sd536870912;
  localparam logic signed [42:0]    SIXT_W    = 43'(bsa_pkg::SIXTEENTH_Q);
  localparam logic signed [43:0]    ESC_W     = 44'(bsa_pkg::ESC_RADIUS);

  function automatic logic signed [MW-1:0] mulq(input logic signed [PW-1:0] p);
    logic [PW-1:0] adj;
    adj = p + {{(PW-QF){1'b0}}, {QF{p[PW-1]}}};
    return $signed(adj[PW-1:QF]);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -44'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // configuration
  logic signed [31:0] xmin_r, ymin_r;
  logic [30:0]        xspan_r, yspan_r;
  logic [31:0]        xppu_r, yppu_r;
  logic [15:0]        limit_r, floor_r;

  // work registers
  logic [63:0]        rnd_a_r, rnd_b_r;
  logic [31:0]        rx_r, ry_r;
  bsa_pkg::op_t       op_r;
  logic [1:0]         ch_r;
  logic [7:0]         px_r, py_r;
  logic signed [31:0] cr_r, ci_r, zr_r, zi_r;
  logic signed [33:0] cici_r, bsq_r;
  logic signed [34:0] q_r, qf_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r;
  logic [15:0]        k_r, hits_r;
  logic               map_r, negx_r, negy_r;
  logic [AW-1:0]      addr_r, clr_r;

  // result
  logic [31:0]        res_count_r;
  logic               res_acc_r;
  logic [15:0]        res_k_r, res_hits_r;
  logic               out_valid_r;
  logic [31:0]        out_count_r;
  logic               out_acc_r;
  logic [15:0]        out_k_r, out_hits_r;

  // memory port
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;

  // xorshift128+ step
  logic [63:0] rnd_x2, rnd_bn, rnd_out;
  always_comb begin
    rnd_x2  = rnd_a_r ^ (rnd_a_r << 23);
    rnd_bn  = rnd_x2 ^ rnd_b_r ^ (rnd_x2 >> 17) ^ (rnd_b_r >> 26);
    rnd_out = rnd_bn + rnd_b_r;
  end

  // operand selection
  logic signed [MLW-1:0] a0, b0, a1, b1, a2, b2, f_v, bo_v;
  logic signed [32:0]    dx, dy;
  logic [32:0]           magx, magy;
  logic                  mul_en;

  always_comb begin
    f_v  = MLW'(cr_r) - QUARTER_M;
    bo_v = MLW'(cr_r) + ONE_M;
    dx   = 33'(zr_r) - 33'(xmin_r);
    dy   = 33'(zi_r) - 33'(ymin_r);
    magx = dx[32] ? 33'(-dx) : dx;
    magy = dy[32] ? 33'(-dy) : dy;
    a0 = '0; b0 = '0; a1 = '0; b1 = '0; a2 = '0; b2 = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      bsa_pkg::DP_PLACE_MUL: begin
        a0 = $signed(MLW'(rx_r)); b0 = $signed(MLW'(xspan_r));
        a1 = $signed(MLW'(ry_r)); b1 = $signed(MLW'(yspan_r));
      end
      bsa_pkg::DP_BULB_MUL: begin
        a0 = MLW'(ci_r); b0 = MLW'(ci_r);
        a1 = f_v;        b1 = f_v;
        a2 = bo_v;       b2 = bo_v;
      end
      bsa_pkg::DP_CARD_MUL: begin
        a0 = q_r; b0 = qf_r;
      end
      bsa_pkg::DP_ORB_MUL: begin
        a0 = MLW'(zr_r); b0 = MLW'(zr_r);
        a1 = MLW'(zi_r); b1 = MLW'(zi_r);
        a2 = MLW'(zr_r); b2 = MLW'(zi_r);
      end
      bsa_pkg::DP_MAP_MUL: begin
        a0 = $signed(MLW'(magx)); b0 = $signed(MLW'(xppu_r));
        a1 = $signed(MLW'(magy)); b1 = $signed(MLW'(yppu_r));
      end
      default: mul_en = 1'b0;
    endcase
  end

  // arithmetic on registered products
  logic signed [43:0]   xsum, ysum, zr_v, zi_v, esc_v;
  logic signed [MW-1:0] m0, m1, m2;
  logic signed [42:0]   card_v, bulb2_v, q_v;
  logic                 outside, in_bulb, escaped, inx, iny, rd_ok, ch_ok;
  logic [TW-1:0]        tx, ty;
  logic [AW-1:0]        map_addr, rd_addr;

  always_comb begin
    m0   = mulq(p0_r);
    m1   = mulq(p1_r);
    m2   = mulq(p2_r);
    xsum = 44'(xmin_r) + $signed(44'(p0_r[62:32]));
    ysum = 44'(ymin_r) + $signed(44'(p1_r[62:32]));
    q_v  = 43'(m1) + 43'(m0);
    card_v  = 43'(m0) - 43'(cici_r >>> 2);
    bulb2_v = 43'(bsq_r) + 43'(cici_r) - SIXT_W;
    outside = (cr_r <= -TWO_Q) || (cr_r >= TWO_Q) || (ci_r <= -TWO_Q) || (ci_r >= TWO_Q);
    in_bulb = !outside && (card_v[42] || bulb2_v[42]);
    zr_v    = 44'(m0) - 44'(m1) + 44'(cr_r);
    zi_v    = (44'(m2) <<< 1) + 44'(ci_r);
    esc_v   = 44'(m0) + 44'(m1);
    escaped = esc_v > ESC_W;
    tx  = p0_r[PW-1:PIX_SHIFT];
    ty  = p1_r[PW-1:PIX_SHIFT];
    inx = (!negx_r || tx == '0) && (tx < TW'(FRAME_WIDTH));
    iny = (!negy_r || ty == '0) && (ty < TW'(FRAME_HEIGHT));
    ch_ok = 32'(ch_r) < CHANNELS;
    rd_ok = ch_ok && (32'(px_r) < FRAME_WIDTH) && (32'(py_r) < FRAME_HEIGHT);
    map_addr = AW'(ch_r) * AW'(BANK) + AW'(ty[YW-1:0]) * AW'(FRAME_WIDTH)
             + AW'(tx[XW-1:0]);
    rd_addr  = AW'(ch_r) * AW'(BANK) + AW'(py_r) * AW'(FRAME_WIDTH) + AW'(px_r);
  end

  // memory control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    ram_raddr = (cmd.op == bsa_pkg::DP_RD_ISSUE) ? rd_addr : map_addr;
    unique case (cmd.op)
      bsa_pkg::DP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      bsa_pkg::DP_MAP_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata + 32'd1;
      end
      bsa_pkg::DP_RD_DONE: begin
        ram_we = rd_ok && (op_r == bsa_pkg::OP_READ_CLR);
      end
      default: ram_we = 1'b0;
    endcase
  end

  bsa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r      <= bsa_pkg::X_MIN_RST;
      ymin_r      <= bsa_pkg::Y_MIN_RST;
      xspan_r     <= bsa_pkg::SPAN_RST;
      yspan_r     <= bsa_pkg::SPAN_RST;
      xppu_r      <= bsa_pkg::PPU_RST;
      yppu_r      <= bsa_pkg::PPU_RST;
      limit_r     <= bsa_pkg::LIMIT_RST;
      floor_r     <= bsa_pkg::FLOOR_RST;
      rnd_a_r     <= 64'd0;
      rnd_b_r     <= 64'd1;
      clr_r       <= '0;
      map_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          bsa_pkg::REG_X_MIN:  xmin_r  <= cfg_data;
          bsa_pkg::REG_Y_MIN:  ymin_r  <= cfg_data;
          bsa_pkg::REG_X_SPAN: xspan_r <= cfg_data[30:0];
          bsa_pkg::REG_Y_SPAN: yspan_r <= cfg_data[30:0];
          bsa_pkg::REG_X_PPU:  xppu_r  <= cfg_data;
          bsa_pkg::REG_Y_PPU:  yppu_r  <= cfg_data;
          bsa_pkg::REG_LIMIT:  limit_r <= cfg_data[15:0];
          bsa_pkg::REG_FLOOR:  floor_r <= cfg_data[15:0];
          default: xmin_r <= xmin_r;
        endcase
      end
      if (cmd.op == bsa_pkg::DP_DRAW_X || cmd.op == bsa_pkg::DP_DRAW_Y) begin
        rnd_a_r <= rnd_b_r;
        rnd_b_r <= rnd_bn;
      end
      if (cmd.op == bsa_pkg::DP_CLEAR) clr_r <= clr_r + AW'(1);
      if (cmd.op == bsa_pkg::DP_PASS_INIT) map_r <= cmd.map;
      if (cmd.op == bsa_pkg::DP_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (mul_en) begin
      p0_r <= a0 * b0;
      p1_r <= a1 * b1;
      p2_r <= a2 * b2;
    end
    if (cmd.k_inc) k_r <= k_r + 16'd1;
    unique case (cmd.op)
      bsa_pkg::DP_LATCH: begin
        op_r <= bsa_pkg::op_t'(in_opcode);
        ch_r <= in_channel;
        px_r <= in_pixel_x;
        py_r <= in_pixel_y;
      end
      bsa_pkg::DP_DRAW_X: rx_r <= rnd_out[63:32];
      bsa_pkg::DP_DRAW_Y: ry_r <= rnd_out[63:32];
      bsa_pkg::DP_PLACE_ADD: begin
        cr_r <= sat32(xsum);
        ci_r <= sat32(ysum);
      end
      bsa_pkg::DP_BULB_SQ: begin
        cici_r <= m0[33:0];
        bsq_r  <= m2[33:0];
        q_r    <= q_v[34:0];
        qf_r   <= q_v[34:0] + f_v;
      end
      bsa_pkg::DP_PASS_INIT: begin
        zr_r   <= '0;
        zi_r   <= '0;
        k_r    <= 16'd1;
        hits_r <= '0;
      end
      bsa_pkg::DP_ORB_UPD: begin
        zr_r <= sat32(zr_v);
        zi_r <= sat32(zi_v);
      end
      bsa_pkg::DP_MAP_MUL: begin
        negx_r <= dx[32];
        negy_r <= dy[32];
      end
      bsa_pkg::DP_MAP_CHK: begin
        addr_r <= map_addr;
        if (inx && iny) hits_r <= hits_r + 16'd1;
      end
      bsa_pkg::DP_RD_ISSUE: addr_r <= rd_addr;
      bsa_pkg::DP_LOAD: begin
        out_count_r <= res_count_r;
        out_acc_r   <= res_acc_r;
        out_k_r     <= res_k_r;
        out_hits_r  <= res_hits_r;
      end
      default: addr_r <= addr_r;
    endcase
    unique case (cmd.res)
      bsa_pkg::RES_ZERO, bsa_pkg::RES_BULB_REJ: begin
        res_count_r <= '0; res_acc_r <= 1'b0; res_k_r <= '0; res_hits_r <= '0;
      end
      bsa_pkg::RES_RANGE_REJ: begin
        res_count_r <= '0; res_acc_r <= 1'b0; res_k_r <= k_r; res_hits_r <= '0;
      end
      bsa_pkg::RES_SAMPLE_OK: begin
        res_count_r <= '0; res_acc_r <= 1'b1; res_k_r <= k_r; res_hits_r <= hits_r;
      end
      bsa_pkg::RES_READ: begin
        res_count_r <= rd_ok ? ram_rdata : 32'd0;
        res_acc_r   <= 1'b0; res_k_r <= '0; res_hits_r <= '0;
      end
      default: res_acc_r <= res_acc_r;
    endcase
  end

  always_comb begin
    sts.clr_last     = clr_r == AW'(DEPTH - 1);
    sts.in_bulb      = in_bulb;
    sts.k_lt_limit   = k_r < limit_r;
    sts.escaped      = escaped;
    sts.reject_range = (k_r < floor_r) || (k_r == limit_r);
    sts.in_frame     = inx && iny;
    sts.ch_ok        = ch_ok;
    sts.map          = map_r;
    sts.out_free     = !out_valid_r || out_ready;
  end

  assign out_valid             = out_valid_r;
  assign out_pixel_count       = out_count_r;
  assign out_sample_accepted   = out_acc_r;
  assign out_escape_iterations = out_k_r;
  assign out_in_frame_hits     = out_hits_r;

endmodule

`default_nettype wire

/* rtl/bsa_checker.sv */
// ----------------------------------------------------------------------------
// bsa_checker
// Port level checks of the sampler result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_pixel_count,
  input wire        out_sample_accepted,
  input wire [15:0] out_escape_iterations,
  input wire [15:0] out_in_frame_hits
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_count) && $stable(out_escape_iterations))
    else $error("result changed while stalled");

  a_accept_k: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_accepted |-> out_escape_iterations != 16'd0
      && out_pixel_count == 32'd0)
    else $error("accepted sample without escape count");

  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_count != 32'd0 |-> !out_sample_accepted
      && out_escape_iterations == 16'd0 && out_in_frame_hits == 16'd0)
    else $error("read result mixed with sample fields");

  a_hits_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_frame_hits != 16'd0 |-> out_sample_accepted)
    else $error("hits reported for rejected sample");

endmodule

bind buddhabrot_sample_accumulator bsa_checker u_bsa_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_ch.valid),
  .out_ready             (out_ch.ready),
  .out_pixel_count       (out_ch.pixel_count),
  .out_sample_accepted   (out_ch.sample_accepted),
  .out_escape_iterations (out_ch.escape_iterations),
  .out_in_frame_hits     (out_ch.in_frame_hits)
);

`default_nettype wire
